// ===== hw/rtl/spq_pkg.sv =====
// ============================================================================
// Stable priority queue package
// Shared defaults, codes and control types for the sorted cell chain.
// ============================================================================
package spq_pkg;

    localparam int DEPTH_DEFAULT          = 16;
    localparam int PAYLOAD_WIDTH_DEFAULT  = 32;
    localparam int PRIORITY_WIDTH_DEFAULT = 16;

    // Operation codes carried on the input beat.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Command broadcast to every cell of the chain at once.
    typedef struct packed {
        logic insert;   // Sorted insert of the broadcast entry.
        logic shift;    // Every entry moves one place toward the head.
    } spq_ctrl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// ============================================================================
// Stable priority queue cell
// One slot of the sorted chain: holds an entry and picks its next value from
// itself, its neighbors or the broadcast entry.
// ============================================================================
module spq_cell
    import spq_pkg::*;
#(
    parameter int PAYLOAD_WIDTH  = PAYLOAD_WIDTH_DEFAULT,
    parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEFAULT
)
(
    input  logic                             clk,
    input  spq_ctrl_t                        ctrl,
    input  logic                             occupied,
    input  logic signed [PRIORITY_WIDTH-1:0] new_priority,
    input  logic        [PAYLOAD_WIDTH-1:0]  new_payload,
    input  logic                             prev_keep,
    input  logic signed [PRIORITY_WIDTH-1:0] prev_priority,
    input  logic        [PAYLOAD_WIDTH-1:0]  prev_payload,
    input  logic signed [PRIORITY_WIDTH-1:0] succ_priority,
    input  logic        [PAYLOAD_WIDTH-1:0]  succ_payload,
    output logic                             keep,
    output logic signed [PRIORITY_WIDTH-1:0] priority_q,
    output logic        [PAYLOAD_WIDTH-1:0]  payload_q,
    output logic signed [PRIORITY_WIDTH-1:0] priority_d,
    output logic        [PAYLOAD_WIDTH-1:0]  payload_d
);

    logic signed [PRIORITY_WIDTH-1:0] priority_reg;
    logic        [PAYLOAD_WIDTH-1:0]  payload_reg;
    logic signed [PRIORITY_WIDTH-1:0] priority_next;
    logic        [PAYLOAD_WIDTH-1:0]  payload_next;

    // An occupied entry of equal or lower priority value stays ahead of a new one.
    assign keep = occupied && (priority_reg <= new_priority);

    always_comb
    begin
        priority_next = priority_reg;
        payload_next  = payload_reg;
        if (ctrl.insert)
        begin
            if (!keep)
            begin
                if (prev_keep)
                begin
                    priority_next = new_priority;
                    payload_next  = new_payload;
                end
                else
                begin
                    priority_next = prev_priority;
                    payload_next  = prev_payload;
                end
            end
        end
        else if (ctrl.shift)
        begin
            priority_next = succ_priority;
            payload_next  = succ_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        priority_reg <= priority_next;
        payload_reg  <= payload_next;
    end

    assign priority_q = priority_reg;
    assign payload_q  = payload_reg;
    assign priority_d = priority_next;
    assign payload_d  = payload_next;

endmodule

// ===== hw/rtl/stable_priority_queue.sv =====
// ============================================================================
// Stable priority queue
// Bounded min-first priority queue kept sorted in a chain of cells.
// ============================================================================
// Results are registered: a beat shows in the cycle after its input is accepted.
// Throughput: one operation per cycle while the result register can take a beat;
// each cell compares its priority with the broadcast priority in parallel.
// Reset clears the entry count and the result valid flag; entry contents and the
// result fields are left undefined and are never read before being written.
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH          = DEPTH_DEFAULT,
    parameter int PAYLOAD_WIDTH  = PAYLOAD_WIDTH_DEFAULT,
    parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEFAULT,
    localparam int CountWidth    = $clog2(DEPTH + 1)
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Operation channel.
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             operation,
    input  logic signed [PRIORITY_WIDTH-1:0] priority_req,
    input  logic        [PAYLOAD_WIDTH-1:0]  payload,
    // Result channel.
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic        [1:0]                status,
    output logic        [PAYLOAD_WIDTH-1:0]  removed_payload,
    output logic                             head_valid,
    output logic signed [PRIORITY_WIDTH-1:0] head_priority,
    output logic        [PAYLOAD_WIDTH-1:0]  head_payload,
    output logic        [CountWidth-1:0]     occupancy
);

    // Entry count: cell i holds a live entry exactly when i is below it.
    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;

    // Result register. It decouples the chain from the consumer: a new beat is
    // taken whenever the register is empty or is being drained this cycle.
    logic                             out_valid_reg;
    status_t                          status_reg;
    logic        [PAYLOAD_WIDTH-1:0]  removed_reg;
    logic                             head_valid_reg;
    logic signed [PRIORITY_WIDTH-1:0] head_priority_reg;
    logic        [PAYLOAD_WIDTH-1:0]  head_payload_reg;
    logic        [CountWidth-1:0]     occupancy_reg;

    logic                             in_fire;
    logic                             is_full;
    logic                             is_empty;
    spq_ctrl_t                        ctrl;
    status_t                          status_next;
    logic        [PAYLOAD_WIDTH-1:0]  removed_next;

    // Chain wiring, one slot per cell.
    logic                             cell_keep  [DEPTH];
    logic signed [PRIORITY_WIDTH-1:0] cell_pri_q [DEPTH];
    logic        [PAYLOAD_WIDTH-1:0]  cell_pay_q [DEPTH];
    logic signed [PRIORITY_WIDTH-1:0] cell_pri_d [DEPTH];
    logic        [PAYLOAD_WIDTH-1:0]  cell_pay_d [DEPTH];

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign is_full  = (count_reg == CountWidth'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Decode the accepted beat into the chain command and the result status.
    always_comb
    begin
        ctrl         = '0;
        status_next  = STATUS_DONE;
        removed_next = '0;
        count_next   = count_reg;
        if (in_fire)
        begin
            unique case (operation)
                OP_ENQUEUE:
                begin
                    if (is_full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + CountWidth'(1);
                    end
                end
                OP_DEQUEUE:
                begin
                    if (is_empty)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        ctrl.shift   = 1'b1;
                        removed_next = cell_pay_q[0];
                        count_next   = count_reg - CountWidth'(1);
                    end
                end
                default:
                begin
                    status_next = STATUS_DONE;
                end
            endcase
        end
    end

    // The sorted chain. The head cell sees a virtual neighbor that always keeps
    // its place, so a new entry that goes before everything lands in cell 0.
    // The tail cell takes zeros on a removal; that slot is beyond the count.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                             prev_keep;
        logic signed [PRIORITY_WIDTH-1:0] prev_pri;
        logic        [PAYLOAD_WIDTH-1:0]  prev_pay;
        logic signed [PRIORITY_WIDTH-1:0] succ_pri;
        logic        [PAYLOAD_WIDTH-1:0]  succ_pay;

        if (i == 0)
        begin : g_head
            assign prev_keep = 1'b1;
            assign prev_pri  = '0;
            assign prev_pay  = '0;
        end
        else
        begin : g_link
            assign prev_keep = cell_keep[i-1];
            assign prev_pri  = cell_pri_q[i-1];
            assign prev_pay  = cell_pay_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign succ_pri = '0;
            assign succ_pay = '0;
        end
        else
        begin : g_body
            assign succ_pri = cell_pri_q[i+1];
            assign succ_pay = cell_pay_q[i+1];
        end

        spq_cell #(
            .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
            .PRIORITY_WIDTH (PRIORITY_WIDTH)
        ) u_cell (
            .clk           (clk),
            .ctrl          (ctrl),
            .occupied      (CountWidth'(i) < count_reg),
            .new_priority  (priority_req),
            .new_payload   (payload),
            .prev_keep     (prev_keep),
            .prev_priority (prev_pri),
            .prev_payload  (prev_pay),
            .succ_priority (succ_pri),
            .succ_payload  (succ_pay),
            .keep          (cell_keep[i]),
            .priority_q    (cell_pri_q[i]),
            .payload_q     (cell_pay_q[i]),
            .priority_d    (cell_pri_d[i]),
            .payload_d     (cell_pay_d[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload. The head view is taken from the head cell's next value,
    // so it already reflects this beat's insert or removal.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg     <= status_next;
            removed_reg    <= removed_next;
            occupancy_reg  <= count_next;
            head_valid_reg <= (count_next != '0);
            if (count_next != '0)
            begin
                head_priority_reg <= cell_pri_d[0];
                head_payload_reg  <= cell_pay_d[0];
            end
            else
            begin
                head_priority_reg <= '0;
                head_payload_reg  <= '0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign removed_payload = removed_reg;
    assign head_valid      = head_valid_reg;
    assign head_priority   = head_priority_reg;
    assign head_payload    = head_payload_reg;
    assign occupancy       = occupancy_reg;

    // The count never passes the number of cells.
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountWidth'(DEPTH))
        else $error("entry count exceeds depth");

    // An enqueue into a queue with room grows the count by exactly one.
    a_enqueue_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (operation == OP_ENQUEUE) && !is_full)
        |=> (count_reg == $past(count_reg) + CountWidth'(1)))
        else $error("enqueue did not grow the queue");

    // The two front entries stay in priority order.
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CountWidth'(2)) |-> (cell_pri_q[0] <= cell_pri_q[1]))
        else $error("front entries out of order");

    // A shown head exists exactly when the queue is not empty.
    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (head_valid_reg == (occupancy_reg != '0)))
        else $error("head valid disagrees with occupancy");

endmodule

// ===== tb/stable_priority_queue_tb.sv =====
// ============================================================================
// Stable priority queue testbench
// Drives enqueue and dequeue beats into the sorted queue and checks every
// result beat against a predictor that keeps a sorted copy of the queue,
// or against a result typed by hand. A short directed table covers the
// empty, full and tie cases first. Random segments follow, biased to fill,
// drain or churn the queue, as sender and receiver idle and stall at random.
// ============================================================================
module stable_priority_queue_tb;
    import spq_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int PW    = PAYLOAD_WIDTH_DEFAULT;
    localparam int PRW   = PRIORITY_WIDTH_DEFAULT;
    localparam int CW    = $clog2(DEPTH + 1);

    // Roughly 1800 random beats on top of the directed table.
    localparam int RANDOM_BEATS     = 1800;
    // Long receiver hold-off, long enough to back the block up into its input.
    localparam int LONG_HOLD_CYCLES = 60;
    // Idle cycles that close the run once every result is back.
    localparam int SETTLE_CYCLES    = 8;
    // Watchdog limit, many times the length of the slowest legal run.
    localparam int CYCLE_LIMIT      = 400000;

    // One result beat as the block reports it.
    typedef struct packed {
        status_t         status;
        logic [PW-1:0]   removed;
        logic            head_valid;
        logic [PRW-1:0]  head_pri;
        logic [PW-1:0]   head_pay;
        logic [CW-1:0]   occupancy;
    } queue_view_t;

    localparam queue_view_t UNTYPED = '0;

    // One row of the directed table. A row may repeat its beat several
    // times, with the payload stepped by one on each repeat.
    typedef struct {
        logic            op;
        logic [PRW-1:0]  pri;
        logic [PW-1:0]   pay;
        int              reps;
        logic            typed;
        queue_view_t     view;
    } directed_row_t;

    typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_NOISE } mix_t;
    typedef enum int { SINK_OPEN, SINK_COIN, SINK_PATTERN, SINK_SPARSE } sink_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  operation;
    logic signed [PRW-1:0] priority_req;
    logic [PW-1:0]         payload;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            status;
    logic [PW-1:0]         removed_payload;
    logic                  head_valid;
    logic signed [PRW-1:0] head_priority;
    logic [PW-1:0]         head_payload;
    logic [CW-1:0]         occupancy;

    // A directed beat may carry its result typed in by hand. These travel
    // with the beat so that the scoreboard picks them up at acceptance.
    logic                  beat_typed;
    queue_view_t           beat_view;

    // Sorted copy of the queue contents, head first.
    logic signed [PRW-1:0] sorted_pri[$];
    logic [PW-1:0]         sorted_pay[$];
    // Results still owed by the block, oldest first.
    queue_view_t           pending_views[$];

    logic                  hold_request;
    int unsigned           burst_left;
    bit                    sender_steady;
    int unsigned           error_count;
    int unsigned           beats_sent;
    int unsigned           results_checked;
    int unsigned           full_drops;
    int unsigned           empty_dequeues;
    int unsigned           peak_occupancy;
    int unsigned           long_holds;
    int unsigned           drain_pauses;
    int unsigned           cycle_count;

    stable_priority_queue u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .priority_req    (priority_req),
        .payload         (payload),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .removed_payload (removed_payload),
        .head_valid      (head_valid),
        .head_priority   (head_priority),
        .head_payload    (head_payload),
        .occupancy       (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Predictor: applies one operation to the sorted copy and returns the
    // result beat the block should report for it. A new entry goes after
    // every entry of equal or smaller priority, which keeps ties in order.
    function automatic queue_view_t next_queue_view(input logic op,
                                                    input logic signed [PRW-1:0] pri,
                                                    input logic [PW-1:0] pay);
        queue_view_t view;
        int          pos;
        view = '0;
        view.status = STATUS_DONE;
        if (op == OP_ENQUEUE)
        begin
            if (sorted_pri.size() >= DEPTH)
            begin
                view.status = STATUS_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < sorted_pri.size() && sorted_pri[pos] <= pri)
                begin
                    pos++;
                end
                sorted_pri.insert(pos, pri);
                sorted_pay.insert(pos, pay);
            end
        end
        else if (sorted_pri.size() == 0)
        begin
            view.status = STATUS_EMPTY;
        end
        else
        begin
            view.removed = sorted_pay.pop_front();
            void'(sorted_pri.pop_front());
        end
        if (sorted_pri.size() != 0)
        begin
            view.head_valid = 1'b1;
            view.head_pri   = sorted_pri[0];
            view.head_pay   = sorted_pay[0];
        end
        view.occupancy = CW'(sorted_pri.size());
        return view;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Scoreboard. Both handshakes are sampled at the rising edge, so the
    // values seen are the ones the block saw. An accepted operation beat
    // is predicted before the result side is checked.
    always @(posedge clk)
    begin : scoreboard
        queue_view_t predicted;
        queue_view_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predicted = next_queue_view(operation, priority_req, payload);
                pending_views.push_back(beat_typed ? beat_view : predicted);
            end
            if (out_valid && out_ready)
            begin
                if (pending_views.size() == 0)
                begin
                    $display("%0t: result beat with none expected, status %0d occupancy %0d",
                             $time, status, occupancy);
                    error_count++;
                end
                else
                begin
                    want = pending_views.pop_front();
                    compare_field("status", want.status, status);
                    compare_field("removed_payload", want.removed, removed_payload);
                    compare_field("head_valid", want.head_valid, head_valid);
                    compare_field("head_priority", want.head_pri, $unsigned(head_priority));
                    compare_field("head_payload", want.head_pay, head_payload);
                    compare_field("occupancy", want.occupancy, occupancy);
                    results_checked++;
                    if (want.status == STATUS_FULL)
                    begin
                        full_drops++;
                    end
                    if (want.status == STATUS_EMPTY)
                    begin
                        empty_dequeues++;
                    end
                    if (want.occupancy > peak_occupancy)
                    begin
                        peak_occupancy = 32'(want.occupancy);
                    end
                end
            end
        end
    end

    // Receiver. It changes its stall pattern at random intervals and,
    // when the sender asks, holds off completely for a long stretch so the
    // result register stays full and the block has to stall its input.
    initial
    begin : result_sink
        int unsigned phase_cycles;
        sink_mode_t  sink_mode;
        out_ready    = 1'b0;
        phase_cycles = 0;
        sink_mode    = SINK_OPEN;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
                long_holds++;
            end
            else
            begin
                if (phase_cycles == 0)
                begin
                    sink_mode    = sink_mode_t'($urandom_range(0, 3));
                    phase_cycles = $urandom_range(40, 200);
                end
                phase_cycles--;
                case (sink_mode)
                    SINK_OPEN:    out_ready <= 1'b1;
                    SINK_COIN:    out_ready <= 1'($urandom_range(0, 1));
                    SINK_PATTERN: out_ready <= (phase_cycles % 5) < 3;
                    default:      out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timed out after %0d cycles with %0d results outstanding",
                 $time, cycle_count, pending_views.size());
        $display("stable_priority_queue test failed");
        $finish;
    end

    // Sender. Beats go out in bursts of random length; between bursts the
    // valid drops for a random number of cycles, unless the current segment
    // runs steady. The task is entered and left at a rising edge, and valid
    // is only lowered at an edge where the previous beat was taken.
    task automatic offer_beat(input logic op, input logic [PRW-1:0] pri,
                              input logic [PW-1:0] pay, input logic typed,
                              input queue_view_t view);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = sender_steady ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid     <= 1'b1;
        operation    <= op;
        priority_req <= pri;
        payload      <= pay;
        beat_typed   <= typed;
        beat_view    <= view;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        beats_sent++;
    endtask

    // Stops offering and waits until every owed result has come back. It
    // waits for an edge first, so the scoreboard has seen the last beat.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_views.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        directed_row_t   directed_rows[13];
        mix_t            mix;
        int unsigned     seg_len;
        int unsigned     seg_index;
        int unsigned     random_sent;
        logic            op;
        logic [PRW-1:0]  pri;
        logic [PW-1:0]   pay;
        logic [PW-1:0]   tag_seq;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = OP_ENQUEUE;
        priority_req  = '0;
        payload       = '0;
        beat_typed    = 1'b0;
        beat_view     = UNTYPED;
        hold_request  = 1'b0;
        burst_left    = 0;
        sender_steady = 1'b0;
        error_count     = 0;
        beats_sent      = 0;
        results_checked = 0;
        full_drops      = 0;
        empty_dequeues  = 0;
        peak_occupancy  = 0;
        long_holds      = 0;
        drain_pauses    = 0;
        tag_seq         = '0;
        seg_index       = 0;
        random_sent     = 0;

        // Directed table. Dequeue rows carry junk in the entry fields, which
        // the block must ignore. The tie rows check that equal priorities
        // leave in arrival order; the long enqueue row fills the queue so
        // that the next enqueue is dropped.
        directed_rows = '{
            '{OP_DEQUEUE, 16'h1234, 32'hCAFE_F00D, 1, 1'b1,
              '{STATUS_EMPTY, 32'h0, 1'b0, 16'h0000, 32'h0, CW'(0)}},
            '{OP_ENQUEUE, 16'h0000, 32'h0000_0001, 1, 1'b1,
              '{STATUS_DONE, 32'h0, 1'b1, 16'h0000, 32'h0000_0001, CW'(1)}},
            '{OP_ENQUEUE, 16'h7FFF, 32'hFFFF_FFFF, 1, 1'b1,
              '{STATUS_DONE, 32'h0, 1'b1, 16'h0000, 32'h0000_0001, CW'(2)}},
            '{OP_ENQUEUE, 16'h8000, 32'hA5A5_A5A5, 1, 1'b1,
              '{STATUS_DONE, 32'h0, 1'b1, 16'h8000, 32'hA5A5_A5A5, CW'(3)}},
            '{OP_ENQUEUE, 16'h8000, 32'h5A5A_5A5A, 1, 1'b0, UNTYPED},
            '{OP_ENQUEUE, 16'h0000, 32'h0000_0002, 1, 1'b0, UNTYPED},
            '{OP_DEQUEUE, 16'h7FFF, 32'hFFFF_FFFF, 1, 1'b0, UNTYPED},
            '{OP_DEQUEUE, 16'h8000, 32'h0000_0000, 1, 1'b0, UNTYPED},
            '{OP_DEQUEUE, 16'h0000, 32'h0000_0000, 1, 1'b0, UNTYPED},
            '{OP_ENQUEUE, 16'h0064, 32'h0000_0100, 14, 1'b0, UNTYPED},
            '{OP_ENQUEUE, 16'hFFFF, 32'hDEAD_BEEF, 1, 1'b1,
              '{STATUS_FULL, 32'h0, 1'b1, 16'h0000, 32'h0000_0002, CW'(16)}},
            '{OP_DEQUEUE, 16'h0000, 32'h0000_0000, 1, 1'b0, UNTYPED},
            '{OP_ENQUEUE, 16'h7FFF, 32'h0000_0077, 1, 1'b0, UNTYPED}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            for (int k = 0; k < directed_rows[r].reps; k++)
            begin
                offer_beat(directed_rows[r].op, directed_rows[r].pri,
                           directed_rows[r].pay + PW'(k), directed_rows[r].typed,
                           directed_rows[r].view);
            end
        end

        // Random segments. Each segment leans toward filling, draining,
        // churning at an even mix, or pure noise. Narrow priorities make
        // ties common; the extremes and full-range values come in between.
        while (random_sent < RANDOM_BEATS)
        begin
            seg_len       = $urandom_range(16, 96);
            mix           = mix_t'($urandom_range(0, 3));
            sender_steady = ($urandom_range(0, 3) == 0);
            if (seg_index % 6 == 2)
            begin
                // Keep offering mostly enqueues while the receiver holds off.
                mix          = MIX_FILL;
                hold_request = 1'b1;
            end
            if (seg_index % 5 == 4)
            begin
                wait_for_results();
                drain_pauses++;
            end
            repeat (seg_len)
            begin
                case (mix)
                    MIX_FILL:  op = ($urandom_range(0, 99) < 85) ? OP_ENQUEUE : OP_DEQUEUE;
                    MIX_DRAIN: op = ($urandom_range(0, 99) < 85) ? OP_DEQUEUE : OP_ENQUEUE;
                    default:   op = $urandom_range(0, 1) ? OP_DEQUEUE : OP_ENQUEUE;
                endcase
                if (mix == MIX_NOISE)
                begin
                    pri = PRW'($urandom);
                end
                else
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: pri = PRW'(int'($urandom_range(0, 6)) - 3);
                        5, 6, 7:       pri = PRW'($urandom);
                        8:             pri = {1'b0, {(PRW-1){1'b1}}};
                        default:       pri = {1'b1, {(PRW-1){1'b0}}};
                    endcase
                end
                // Serial tags make the order of ties easy to follow in a log.
                if ($urandom_range(0, 1))
                begin
                    tag_seq++;
                    pay = tag_seq;
                end
                else
                begin
                    pay = PW'($urandom);
                end
                offer_beat(op, pri, pay, 1'b0, UNTYPED);
                random_sent++;
            end
            seg_index++;
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d operation beats and checked %0d result beats in %0d cycles.",
                 beats_sent, results_checked, cycle_count);
        $display("Saw %0d dropped enqueues, %0d empty dequeues, peak occupancy %0d, %0d long holds.",
                 full_drops, empty_dequeues, peak_occupancy, long_holds);
        if (error_count == 0)
        begin
            $display("stable_priority_queue test passed");
        end
        else
        begin
            $display("stable_priority_queue test failed");
        end
        $finish;
    end

endmodule
